// File: hw/rtl/mer_pkg.sv
`timescale 1ns / 1ps

package mer_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int AXIS_W = 12;
    localparam int HALF_W = 11;
    localparam int SQ_W   = 2 * AXIS_W;
    localparam int MOP_W  = AXIS_W + 1;
    localparam int PROD_W = SQ_W + MOP_W;
    localparam int DEC_W  = 44;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_LSB = 2;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(256);

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic REG_HALF_WIDTH  = 1'b0;
    localparam logic REG_HALF_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        RG_IDLE,
        RG_ONE,
        RG_TWO
    } t_region;

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_SQ_A,
        ST_SQ_B,
        ST_INIT_MUL,
        ST_INIT_SET,
        ST_MUL_INC,
        ST_MUL_DEC,
        ST_MUL_CMP,
        ST_UPDATE,
        ST_R2_LOAD,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_A,
        OP_SQ_B,
        OP_MUL_INIT,
        OP_SET_INIT,
        OP_STEP,
        OP_MUL_INC,
        OP_MUL_DEC,
        OP_MUL_CMP,
        OP_UPDATE,
        OP_REGION_TWO,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic points_valid;
        logic last_point;
        logic axis_error;
    } t_flags;

    typedef struct packed {
        t_dp_op op;
        logic   swap;
        t_flags flags;
    } t_dp_cmd;

    typedef struct packed {
        logic axis_bad;
        logic holds;
        logic out_free;
    } t_dp_status;

endpackage

// File: hw/rtl/mer_if.sv
`timescale 1ns / 1ps

interface mer_in_if import mer_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [AXIS_W-1:0] semi_axis_x;
    logic [AXIS_W-1:0] semi_axis_y;

    modport source (output valid, cmd, semi_axis_x, semi_axis_y, input ready);
    modport sink   (input valid, cmd, semi_axis_x, semi_axis_y, output ready);
endinterface

interface mer_out_if import mer_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF) ();
    logic                  valid;
    logic                  ready;
    logic                  points_valid;
    logic                  last_point;
    logic                  axis_error;
    logic [COORD_BITS-1:0] col_right;
    logic [COORD_BITS-1:0] col_left;
    logic [COORD_BITS-1:0] row_down;
    logic [COORD_BITS-1:0] row_up;

    modport source (
        output valid, points_valid, last_point, axis_error,
        output col_right, col_left, row_down, row_up,
        input  ready
    );
    modport sink (
        input  valid, points_valid, last_point, axis_error,
        input  col_right, col_left, row_down, row_up,
        output ready
    );
endinterface

// File: hw/rtl/mer_cfg.sv
`timescale 1ns / 1ps

module mer_cfg import mer_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [HALF_W-1:0] o_half_width,
    output logic [HALF_W-1:0] o_half_height
);

    logic [HALF_W-1:0] r_half_width;
    logic [HALF_W-1:0] r_half_height;
    logic              w_wr;
    logic              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[REG_IDX_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= HALF_RESET;
            r_half_height <= HALF_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_HALF_WIDTH:  r_half_width  <= pwdata[HALF_W-1:0];
                REG_HALF_HEIGHT: r_half_height <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HALF_WIDTH:  prdata = APB_DW'(r_half_width);
            REG_HALF_HEIGHT: prdata = APB_DW'(r_half_height);
            default:         prdata = '0;
        endcase
    end

    assign o_half_width  = r_half_width;
    assign o_half_height = r_half_height;

endmodule

// File: hw/rtl/mer_ctrl.sv
`timescale 1ns / 1ps

module mer_ctrl import mer_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_cmd,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state  r_state,  n_state;
    t_region r_region, n_region;
    t_flags  r_flags,  n_flags;
    t_dp_op  w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_WAIT;
            r_region <= RG_IDLE;
            r_flags  <= '0;
        end else begin
            r_state  <= n_state;
            r_region <= n_region;
            r_flags  <= n_flags;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_region = r_region;
        n_flags  = r_flags;
        w_op     = OP_NONE;
        o_ready  = 1'b0;
        case (r_state)
            ST_WAIT: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_cmd == CMD_START) begin
                        if (i_status.axis_bad) begin
                            n_region = RG_IDLE;
                            n_flags  = '{points_valid: 1'b0, last_point: 1'b1,
                                         axis_error: 1'b1};
                            n_state  = ST_EMIT;
                        end else begin
                            w_op     = OP_LOAD;
                            n_region = RG_ONE;
                            n_flags  = '{points_valid: 1'b0, last_point: 1'b0,
                                         axis_error: 1'b0};
                            n_state  = ST_SQ_A;
                        end
                    end else if (r_region == RG_IDLE) begin
                        n_flags = '{points_valid: 1'b0, last_point: 1'b1, axis_error: 1'b0};
                        n_state = ST_EMIT;
                    end else begin
                        w_op    = OP_STEP;
                        n_state = ST_MUL_INC;
                    end
                end
            end
            ST_SQ_A: begin
                w_op    = OP_SQ_A;
                n_state = ST_SQ_B;
            end
            ST_SQ_B: begin
                w_op    = OP_SQ_B;
                n_state = ST_INIT_MUL;
            end
            ST_INIT_MUL: begin
                w_op    = OP_MUL_INIT;
                n_state = ST_INIT_SET;
            end
            ST_INIT_SET: begin
                w_op    = OP_SET_INIT;
                n_state = ST_EMIT;
            end
            ST_MUL_INC: begin
                w_op    = OP_MUL_INC;
                n_state = ST_MUL_DEC;
            end
            ST_MUL_DEC: begin
                w_op    = OP_MUL_DEC;
                n_state = ST_MUL_CMP;
            end
            ST_MUL_CMP: begin
                w_op    = OP_MUL_CMP;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                w_op = OP_UPDATE;
                case (r_region)
                    RG_ONE: begin
                        n_flags = '{points_valid: 1'b1, last_point: 1'b0, axis_error: 1'b0};
                        n_state = i_status.holds ? ST_EMIT : ST_R2_LOAD;
                    end
                    RG_TWO: begin
                        n_flags = '{points_valid: 1'b1, last_point: !i_status.holds,
                                    axis_error: 1'b0};
                        if (!i_status.holds) begin
                            n_region = RG_IDLE;
                        end
                        n_state = ST_EMIT;
                    end
                    default: begin
                        n_flags = '{points_valid: 1'b0, last_point: 1'b1, axis_error: 1'b0};
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_R2_LOAD: begin
                w_op     = OP_REGION_TWO;
                n_region = RG_TWO;
                n_state  = ST_INIT_MUL;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    w_op    = OP_EMIT;
                    n_state = ST_WAIT;
                end
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase
    end

    assign o_cmd.op    = w_op;
    assign o_cmd.swap  = (r_region == RG_TWO);
    assign o_cmd.flags = r_flags;

endmodule

// File: hw/rtl/mer_dp.sv
`timescale 1ns / 1ps

module mer_dp import mer_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [HALF_W-1:0] i_half_width,
    input  logic [HALF_W-1:0] i_half_height,
    input  logic [AXIS_W-1:0] i_semi_axis_x,
    input  logic [AXIS_W-1:0] i_semi_axis_y,
    mer_out_if.source         o_res
);

    localparam int SUM_W = COORD_BITS + AXIS_W;

    logic [AXIS_W-1:0]     r_a, r_b, r_x, r_y, r_px, r_py;
    logic [SQ_W-1:0]       r_a2, r_b2;
    logic [PROD_W-1:0]     r_p1, r_p2, r_p3;
    logic [DEC_W-1:0]      r_d;
    logic                  r_neg;
    logic                  r_out_valid;
    t_flags                r_out_flags;
    logic [COORD_BITS-1:0] r_col_right, r_col_left, r_row_down, r_row_up;

    logic [SQ_W-1:0]   w_cu, w_cv;
    logic [AXIS_W-1:0] w_u, w_v, w_u_inc, w_v_dec;
    logic [SQ_W-1:0]   w_mul_a;
    logic [MOP_W-1:0]  w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [DEC_W-1:0]  w_d_step, w_d_init, w_dec_sub;
    logic [SUM_W-1:0]  w_hw, w_hh, w_px, w_py;
    logic [SUM_W-1:0]  w_right, w_left, w_down, w_up;

    // region two swaps the roles of the axes
    assign w_cu = i_cmd.swap ? r_a2 : r_b2;
    assign w_cv = i_cmd.swap ? r_b2 : r_a2;
    assign w_u  = i_cmd.swap ? r_y : r_x;
    assign w_v  = i_cmd.swap ? r_x : r_y;

    assign w_u_inc = w_u + AXIS_W'(1);
    assign w_v_dec = w_v - AXIS_W'(1);

    always_comb begin
        case (i_cmd.op)
            OP_SQ_A: begin
                w_mul_a = SQ_W'(r_a);
                w_mul_b = MOP_W'(r_a);
            end
            OP_SQ_B: begin
                w_mul_a = SQ_W'(r_b);
                w_mul_b = MOP_W'(r_b);
            end
            OP_MUL_INIT, OP_MUL_DEC: begin
                w_mul_a = w_cv;
                w_mul_b = MOP_W'(w_v);
            end
            OP_MUL_INC: begin
                w_mul_a = w_cu;
                w_mul_b = {w_u, 1'b1};
            end
            OP_MUL_CMP: begin
                w_mul_a = w_cu;
                w_mul_b = MOP_W'(w_u);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    assign w_dec_sub = r_neg ? '0 : {{(DEC_W-PROD_W-3){1'b0}}, r_p2, 3'b000};
    assign w_d_step  = r_d + {{(DEC_W-PROD_W-2){1'b0}}, r_p1, 2'b00} - w_dec_sub;
    assign w_d_init  = {{(DEC_W-SQ_W-2){1'b0}}, w_cu, 2'b00} + DEC_W'(w_cv)
                     - {{(DEC_W-PROD_W-2){1'b0}}, r_p1, 2'b00};

    assign w_hw    = SUM_W'(i_half_width);
    assign w_hh    = SUM_W'(i_half_height);
    assign w_px    = SUM_W'(r_px);
    assign w_py    = SUM_W'(r_py);
    assign w_right = w_hw + w_px;
    assign w_left  = w_hw - w_px;
    assign w_down  = w_hh + w_py;
    assign w_up    = w_hh - w_py;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_a <= i_semi_axis_x;
                r_b <= i_semi_axis_y;
                r_x <= '0;
                r_y <= i_semi_axis_y;
            end
            OP_SQ_A:     r_a2 <= w_prod[SQ_W-1:0];
            OP_SQ_B:     r_b2 <= w_prod[SQ_W-1:0];
            OP_MUL_INIT: r_p1 <= w_prod;
            OP_SET_INIT: r_d  <= w_d_init;
            OP_STEP: begin
                r_px  <= r_x;
                r_py  <= r_y;
                r_neg <= r_d[DEC_W-1];
                if (i_cmd.swap) begin
                    r_y <= w_u_inc;
                    if (!r_d[DEC_W-1]) begin
                        r_x <= w_v_dec;
                    end
                end else begin
                    r_x <= w_u_inc;
                    if (!r_d[DEC_W-1]) begin
                        r_y <= w_v_dec;
                    end
                end
            end
            OP_MUL_INC: r_p1 <= w_prod;
            OP_MUL_DEC: r_p2 <= w_prod;
            OP_MUL_CMP: r_p3 <= w_prod;
            OP_UPDATE:  r_d  <= w_d_step;
            OP_REGION_TWO: begin
                r_x <= r_a;
                r_y <= '0;
            end
            OP_EMIT: begin
                r_out_flags <= i_cmd.flags;
                if (i_cmd.flags.points_valid) begin
                    r_col_right <= w_right[COORD_BITS-1:0];
                    r_col_left  <= w_left[COORD_BITS-1:0];
                    r_row_down  <= w_down[COORD_BITS-1:0];
                    r_row_up    <= w_up[COORD_BITS-1:0];
                end else begin
                    r_col_right <= '0;
                    r_col_left  <= '0;
                    r_row_down  <= '0;
                    r_row_up    <= '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.axis_bad = (i_semi_axis_x == '0) || (i_semi_axis_y == '0)
                             || (i_semi_axis_x > AXIS_W'(i_half_width))
                             || (i_semi_axis_y > AXIS_W'(i_half_height));
    assign o_status.holds    = (r_p3 <= r_p2);
    assign o_status.out_free = !r_out_valid || o_res.ready;

    assign o_res.valid        = r_out_valid;
    assign o_res.points_valid = r_out_flags.points_valid;
    assign o_res.last_point   = r_out_flags.last_point;
    assign o_res.axis_error   = r_out_flags.axis_error;
    assign o_res.col_right    = r_col_right;
    assign o_res.col_left     = r_col_left;
    assign o_res.row_down     = r_row_down;
    assign o_res.row_up       = r_row_up;

endmodule

// File: hw/rtl/midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps

// midpoint ellipse rasterizer
// i_req carries one item per command: start (with both semi-axes) or advance.
// o_res returns exactly one item per accepted command: flags plus the four
// mirrored coordinates around the centre (half_width, half_height).
// the centre registers sit behind the apb port: half_width at 0, half_height at 4.
// states: a start runs sq_a, sq_b, init_mul, init_set, emit; an advance runs
// mul_inc, mul_dec, mul_cmp, update, emit, with r2_load, init_mul, init_set before
// emit when it ends region one; a rejected start or an idle advance goes to emit.
// throughput: one item in flight; the next item is taken once the current one
// sits in the output register. the figure is set by the single shared
// multiplier, used three or four times per advance, and the decision term update.
// a stalled o_res holds its item; one more item may be accepted and worked on,
// then the block waits for the output register to drain.
// reset: synchronous, clears the state machine, returns the ellipse to idle
// and both centre registers to 256.

module midpoint_ellipse_rasterizer import mer_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mer_in_if.sink            i_req,
    mer_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [HALF_W-1:0] w_half_width;
    logic [HALF_W-1:0] w_half_height;
    t_dp_cmd           w_cmd;
    t_dp_status        w_status;
    logic              w_ready;

    mer_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_half_width  (w_half_width),
        .o_half_height (w_half_height)
    );

    mer_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .i_cmd    (i_req.cmd),
        .o_ready  (w_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mer_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_half_width  (w_half_width),
        .i_half_height (w_half_height),
        .i_semi_axis_x (i_req.semi_axis_x),
        .i_semi_axis_y (i_req.semi_axis_y),
        .o_res         (o_res)
    );

    assign i_req.ready = w_ready;

endmodule

// File: hw/rtl/mer_checker.sv
`timescale 1ns / 1ps

module mer_checker import mer_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  i_ready,
    input logic                  i_points_valid,
    input logic                  i_last_point,
    input logic                  i_axis_error,
    input logic [COORD_BITS-1:0] i_col_right,
    input logic [COORD_BITS-1:0] i_col_left,
    input logic [COORD_BITS-1:0] i_row_down,
    input logic [COORD_BITS-1:0] i_row_up
);

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_points_valid)
            && $stable(i_last_point) && $stable(i_axis_error)
            && $stable(i_col_right) && $stable(i_col_left)
            && $stable(i_row_down) && $stable(i_row_up))
        else $error("output item changed while stalled");

    // a rejected start ends the ellipse and plots nothing
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_axis_error |-> i_last_point && !i_points_valid)
        else $error("axis error without last point or with a point");

    // no point means zero coordinates
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_points_valid |-> i_col_right == '0 && i_col_left == '0
            && i_row_down == '0 && i_row_up == '0)
        else $error("coordinates set on an item without a point");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
    .COORD_BITS (COORD_BITS)
) u_mer_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_points_valid (o_res.points_valid),
    .i_last_point   (o_res.last_point),
    .i_axis_error   (o_res.axis_error),
    .i_col_right    (o_res.col_right),
    .i_col_left     (o_res.col_left),
    .i_row_down     (o_res.row_down),
    .i_row_up       (o_res.row_up)
);
